FILE: design/life_pkg.sv
package life_pkg;

  // Largest board side the line buffers hold
  localparam int MAX_SIDE = 50;

  // Width of the size registers and positions
  localparam int SIDE_W = 6;
  localparam int IDX_W  = $clog2(MAX_SIDE);
  // One beat can release up to two row results plus a whole dead bottom row
  localparam int CNT_W  = $clog2(MAX_SIDE + 3);
  localparam int CFG_IDX_W = 2;

  typedef logic [SIDE_W-1:0] side_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  localparam side_t SIDE_LO = side_t'(3);
  localparam side_t SIDE_HI = side_t'(MAX_SIDE);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_COUNT    = 2'd0,
    REG_COLUMN_COUNT = 2'd1
  } reg_index_t;

  // Run of result beats released by one input cell: the first carries
  // alive, the rest are dead, the last one closes the frame if frame_end
  typedef struct packed {
    logic alive;
    logic frame_end;
    cnt_t count;
  } burst_t;

endpackage

FILE: design/life_if.sv
interface life_cell_if import life_pkg::*; ();
  logic valid;
  logic ready;
  logic cell_alive;

  modport source (output valid, output cell_alive, input ready);
  modport sink (input valid, input cell_alive, output ready);
endinterface

interface life_result_if import life_pkg::*; ();
  logic valid;
  logic ready;
  logic next_alive;
  logic frame_last;

  modport source (output valid, output next_alive, output frame_last, input ready);
  modport sink (input valid, input next_alive, input frame_last, output ready);
endinterface

interface life_cfg_if import life_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  side_t                data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: design/life_automaton_generation_core.v.sv
// Result beats leave a registered burst queue: head first, then tail.
// Throughput: one cell per cycle while the tail is free; a row's last column
// adds one result beat, the board's last cell one per column (dead bottom row).
// Reset (rst, synchronous): sizes go to 50, position to row 0 column 0, window
// and line buffer contents read as zero (valid bits cleared at once, no sweep).
module life_automaton_generation_core import life_pkg::*; (
  input logic           clk,
  input logic           rst,
  life_cell_if.sink     cells,
  life_result_if.source results,
  life_cfg_if.sink      cfg
);

  // Size registers and their clamped working values
  side_t row_count;
  side_t column_count;
  side_t rows;
  side_t cols;

  // Raster position of the next input cell
  side_t row_position;
  side_t column_position;
  side_t row_next;
  side_t column_next;

  // Line buffer: bit 0 is the row above, bit 1 the row two above
  logic [1:0]          line_mem [MAX_SIDE];
  logic [MAX_SIDE-1:0] line_valid;
  logic [1:0]          line_rd;
  logic [IDX_W-1:0]    wr_idx;
  logic [IDX_W-1:0]    rd_idx;

  logic [8:0] window_bits;
  logic [8:0] window_next;

  logic cfg_fire;
  logic in_fire;
  logic out_fire;
  logic col_last;
  logic row_last;
  logic final_cell;
  logic cell_next;
  logic head_done;

  // Two-deep burst queue: head drives the result port, tail waits
  burst_t head;
  burst_t tail;
  burst_t head_next;
  burst_t tail_next;
  burst_t fresh;

  function automatic side_t clamp_side(input side_t v);
    side_t r;
    r = v;
    if (v < SIDE_LO) r = SIDE_LO;
    if (v > SIDE_HI) r = SIDE_HI;
    return r;
  endfunction

  // B3/S23 on a 3x3 window, center at bit 4
  function automatic logic life_rule(input logic [8:0] w);
    logic [3:0] n;
    logic       r;
    n = '0;
    for (int i = 0; i < 9; i++) begin
      if (i != 4) n = n + 4'(w[i]);
    end
    r = 1'b0;
    if (n == 4'd3) r = 1'b1;
    if (n == 4'd2) r = w[4];
    return r;
  endfunction

  assign rows = clamp_side(row_count);
  assign cols = clamp_side(column_count);

  assign cfg.ready = 1'b1;
  assign cfg_fire  = cfg.valid & cfg.ready;

  // Accept while the waiting slot is free, even if the head beat is stalled
  assign cells.ready = (tail.count == '0);
  assign in_fire     = cells.valid & cells.ready;

  assign results.valid      = (head.count != '0);
  assign results.next_alive = head.alive;
  assign results.frame_last = head.frame_end & (head.count == cnt_t'(1));
  assign out_fire           = results.valid & results.ready;

  // Window shifts one column left; the new column is top, mid, incoming cell
  assign window_next = {window_bits[5:0], cells.cell_alive, line_rd[0], line_rd[1]};

  assign col_last   = (column_position == cols - side_t'(1));
  assign row_last   = (row_position == rows - side_t'(1));
  assign final_cell = row_last & col_last;

  // Border cells die: only a window that is fully inside the board counts
  assign cell_next = (row_position >= side_t'(2)) && (column_position >= side_t'(2))
                     ? life_rule(window_next) : 1'b0;

  always_comb begin
    fresh.alive     = cell_next;
    fresh.frame_end = final_cell;
    if (row_position == '0) begin
      fresh.count = '0;
    end else if (column_position == '0) begin
      fresh.count = cnt_t'(1);
    end else begin
      fresh.count = cnt_t'(1) + cnt_t'(col_last) + (final_cell ? cnt_t'(cols) : '0);
    end
  end

  // Next raster position; a size write restarts the frame
  always_comb begin
    row_next    = row_position;
    column_next = column_position;
    if (cfg_fire) begin
      row_next    = '0;
      column_next = '0;
    end else if (in_fire) begin
      if (final_cell) begin
        row_next    = '0;
        column_next = '0;
      end else if (col_last) begin
        row_next    = row_position + side_t'(1);
        column_next = '0;
      end else begin
        column_next = column_position + side_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count       <= SIDE_HI;
      column_count    <= SIDE_HI;
      row_position    <= '0;
      column_position <= '0;
    end else begin
      if (cfg_fire) begin
        case (cfg.index)
          REG_ROW_COUNT:    row_count    <= cfg.data;
          REG_COLUMN_COUNT: column_count <= cfg.data;
          default: ;
        endcase
      end
      row_position    <= row_next;
      column_position <= column_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_bits <= '0;
    end else if (in_fire) begin
      window_bits <= window_next;
    end
  end

  // Line buffer: write the column just used, prefetch the next column so the
  // read data is registered and ready when the next beat lands
  assign wr_idx = column_position[IDX_W-1:0];
  assign rd_idx = column_next[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (in_fire) begin
      line_mem[wr_idx] <= {line_rd[0], cells.cell_alive};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_valid <= '0;
    end else if (in_fire) begin
      line_valid[wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_rd <= '0;
    end else if (in_fire && (wr_idx == rd_idx)) begin
      line_rd <= {line_rd[0], cells.cell_alive};
    end else if (line_valid[rd_idx]) begin
      line_rd <= line_mem[rd_idx];
    end else begin
      line_rd <= '0;
    end
  end

  // Burst queue: drain the head one beat at a time, promote the tail
  assign head_done = (head.count == '0) || ((head.count == cnt_t'(1)) && out_fire);

  always_comb begin
    head_next = head;
    tail_next = tail;
    if (head_done) begin
      if (tail.count != '0) begin
        head_next       = tail;
        tail_next.count = '0;
      end else if (in_fire) begin
        head_next = fresh;
      end else begin
        head_next.count = '0;
      end
    end else begin
      if (out_fire) begin
        head_next.count = head.count - cnt_t'(1);
        head_next.alive = 1'b0;
      end
      if (in_fire) begin
        tail_next = fresh;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
    end else begin
      head <= head_next;
      tail <= tail_next;
    end
  end

  // Prefetched line data always matches the buffer at the current column
  a_line_prefetch: assert property (@(posedge clk) disable iff (rst)
    line_rd == (line_valid[column_position[IDX_W-1:0]]
                ? line_mem[column_position[IDX_W-1:0]] : 2'b00))
    else $error("line buffer prefetch out of step with position");

  // A waiting burst never sits behind an empty head
  a_queue_order: assert property (@(posedge clk) disable iff (rst)
    (tail.count != '0) |-> (head.count != '0))
    else $error("burst queue tail held with empty head");

  // The frame-closing beat is a border cell and therefore dead
  a_last_dead: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.frame_last) |-> !results.next_alive)
    else $error("frame_last beat carries a live cell");

  // The last cell of the board wraps the raster position
  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    (in_fire && final_cell && !cfg_fire) |=> (row_position == '0 && column_position == '0))
    else $error("position did not wrap after the final cell");

endmodule

FILE: bench/tb_life_automaton_generation_core.sv
`timescale 1ns / 1ps

module tb_life_automaton_generation_core;
  import life_pkg::*;

  // Run shaping
  localparam int DIRECTED_CELLS = 25;
  localparam int RANDOM_CELLS   = 185;
  localparam int MAX_BURST      = 40;
  localparam int MAX_GAP        = 12;
  // Quiet cycles before a register write; the core may still be busy on a
  // cell that gives no result beat.
  localparam int SETTLE_CYCLES  = 4;
  localparam int TAIL_CYCLES    = 60;
  // Long receiver hold-off; the core fills up and stalls its cell input.
  localparam int HOLD_CYCLES    = 300;
  // Longest correct quiet stretch is the hold-off above; allow a wide margin.
  localparam int WATCHDOG_LIMIT = 2000;

  // Life rule counts
  localparam int BIRTH_COUNT = 3;
  localparam int KEEP_COUNT  = 2;

  // Indexes past the register list: they only restart the frame
  localparam logic [CFG_IDX_W-1:0] IDX_UNMAPPED_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] IDX_UNMAPPED_HI = 2'd3;

  typedef struct packed {
    logic alive;
    logic frame_end;
  } next_cell_t;

  localparam next_cell_t DEAD_INNER = '{1'b0, 1'b0};

  typedef enum logic {STEP_WRITE, STEP_CELL} step_kind_t;

  typedef struct packed {
    step_kind_t           kind;
    logic [CFG_IDX_W-1:0] index;
    side_t                data;
    logic                 alive;
    logic                 typed;
    next_cell_t           typed_res;
  } plan_step_t;

  typedef enum int {STALL_NONE, STALL_COIN, STALL_EVERY_THIRD, STALL_HEAVY} stall_mode_t;

  // Directed walk. Index is a don't-care on cell rows. A typed row gives the
  // first result beat of that cell by hand: a column-0 cell of row 1 always
  // releases the dead left border cell of row 0.
  localparam plan_step_t DIRECTED_PLAN [31] = '{
    // Sizes below the floor clamp to a 3x3 board
    '{STEP_WRITE, REG_ROW_COUNT,    6'd0,  1'b0, 1'b0, DEAD_INNER},
    '{STEP_WRITE, REG_COLUMN_COUNT, 6'd2,  1'b0, 1'b0, DEAD_INNER},
    // Three live neighbours around a dead center: birth
    '{STEP_CELL,  REG_ROW_COUNT,    6'd0,  1'b1, 1'b0, DEAD_INNER},
    '{STEP_CELL,  REG_ROW_COUNT,    6'd0,  1'b1, 1'b0, DEAD_INNER},
    '{STEP_CELL,  REG_ROW_COUNT,    6'd0,  1'b0, 1'b0, DEAD_INNER},
    '{STEP_CELL,  REG_ROW_COUNT,    6'd0,  1'b0, 1'b1, DEAD_INNER},
    '{STEP_CELL,  REG_ROW_COUNT,    6'd0,  1'b0, 1'b0, DEAD_INNER},
    '{STEP_CELL,  REG_ROW_COUNT,    6'd0,  1'b0, 1'b0, DEAD_INNER},
    '{STEP_CELL,  REG_ROW_COUNT,    6'd0,  1'b0, 1'b0, DEAD_INNER},
    '{STEP_CELL,  REG_ROW_COUNT,    6'd0,  1'b0, 1'b0, DEAD_INNER},
    '{STEP_CELL,  REG_ROW_COUNT,    6'd0,  1'b1, 1'b0, DEAD_INNER},
    // Frame end wrapped: these land on row 0 of the next frame
    '{STEP_CELL,  REG_ROW_COUNT,    6'd0,  1'b1, 1'b0, DEAD_INNER},
    '{STEP_CELL,  REG_ROW_COUNT,    6'd0,  1'b1, 1'b0, DEAD_INNER},
    // Writes past the register list only restart the frame
    '{STEP_WRITE, IDX_UNMAPPED_LO,  6'h2A, 1'b0, 1'b0, DEAD_INNER},
    '{STEP_CELL,  REG_ROW_COUNT,    6'd0,  1'b0, 1'b0, DEAD_INNER},
    '{STEP_CELL,  REG_ROW_COUNT,    6'd0,  1'b1, 1'b0, DEAD_INNER},
    '{STEP_WRITE, IDX_UNMAPPED_HI,  6'h3F, 1'b0, 1'b0, DEAD_INNER},
    // 3x4 board: one interior cell lives on three, the other keeps on two
    '{STEP_WRITE, REG_ROW_COUNT,    6'd3,  1'b0, 1'b0, DEAD_INNER},
    '{STEP_WRITE, REG_COLUMN_COUNT, 6'd4,  1'b0, 1'b0, DEAD_INNER},
    '{STEP_CELL,  REG_ROW_COUNT,    6'd0,  1'b1, 1'b0, DEAD_INNER},
    '{STEP_CELL,  REG_ROW_COUNT,    6'd0,  1'b0, 1'b0, DEAD_INNER},
    '{STEP_CELL,  REG_ROW_COUNT,    6'd0,  1'b1, 1'b0, DEAD_INNER},
    '{STEP_CELL,  REG_ROW_COUNT,    6'd0,  1'b0, 1'b0, DEAD_INNER},
    '{STEP_CELL,  REG_ROW_COUNT,    6'd0,  1'b0, 1'b1, DEAD_INNER},
    '{STEP_CELL,  REG_ROW_COUNT,    6'd0,  1'b1, 1'b0, DEAD_INNER},
    '{STEP_CELL,  REG_ROW_COUNT,    6'd0,  1'b1, 1'b0, DEAD_INNER},
    '{STEP_CELL,  REG_ROW_COUNT,    6'd0,  1'b0, 1'b0, DEAD_INNER},
    '{STEP_CELL,  REG_ROW_COUNT,    6'd0,  1'b0, 1'b0, DEAD_INNER},
    '{STEP_CELL,  REG_ROW_COUNT,    6'd0,  1'b0, 1'b0, DEAD_INNER},
    '{STEP_CELL,  REG_ROW_COUNT,    6'd0,  1'b0, 1'b0, DEAD_INNER},
    '{STEP_CELL,  REG_ROW_COUNT,    6'd0,  1'b0, 1'b0, DEAD_INNER}
  };

  logic clk = 1'b0;
  logic rst;

  life_cell_if   cells_if ();
  life_result_if results_if ();
  life_cfg_if    cfg_if ();

  life_automaton_generation_core dut (
    .clk     (clk),
    .rst     (rst),
    .cells   (cells_if),
    .results (results_if),
    .cfg     (cfg_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: own copy of the line buffers, window, raster position
  // and size registers
  logic       line_buf [2*MAX_SIDE];
  logic [8:0] nbhd;
  side_t      row_at, col_at;
  side_t      rows_reg, cols_reg;

  // Next-generation cells still owed by the core, oldest first
  next_cell_t next_gen_q [$];

  int errors          = 0;
  int cells_sent      = 0;
  int burst_left      = 0;
  int holds_requested = 0;
  int holds_served    = 0;
  int quiet_cycles    = 0;
  bit cell_offer      = 1'b0;

  function automatic side_t clamp_side(input side_t v);
    if (v < SIDE_LO) return SIDE_LO;
    if (v > SIDE_HI) return SIDE_HI;
    return v;
  endfunction

  // Append one owed result beat behind the ones already waiting
  function automatic void owe_cell(input next_cell_t beat);
    next_gen_q = {next_gen_q, beat};
  endfunction

  // Advance the board by one accepted cell; queue every result beat it releases.
  task automatic step_generation(input logic bot);
    side_t rows, cols, r, c;
    logic  mid, top, born;
    int    live_n, i, j;
    rows = clamp_side(rows_reg);
    cols = clamp_side(cols_reg);
    r = (row_at >= rows) ? rows - side_t'(1) : row_at;
    c = (col_at >= cols) ? cols - side_t'(1) : col_at;

    // Shift the new column in: top row at bit 0, current row at bit 2
    mid = line_buf[c];
    top = line_buf[MAX_SIDE + c];
    nbhd = {nbhd[5:0], bot, mid, top};
    line_buf[MAX_SIDE + c] = mid;
    line_buf[c] = bot;

    if (r >= 1) begin
      if (c == 0) begin
        owe_cell(DEAD_INNER);
      end else begin
        born = 1'b0;
        // Only a window that sits wholly on the board judges an interior cell
        if (r >= 2 && c >= 2) begin
          live_n = 0;
          for (i = 0; i < 9; i++)
            if (i != 4) live_n += nbhd[i];
          born = (live_n == BIRTH_COUNT) || (live_n == KEEP_COUNT && nbhd[4]);
        end
        owe_cell(next_cell_t'{born, 1'b0});
        // Right border cell of the row above
        if (c == cols - 1) owe_cell(DEAD_INNER);
      end
    end

    if (r == rows - 1 && c == cols - 1) begin
      // Flush the dead bottom row and wrap to the top
      for (j = 0; j < cols; j++)
        owe_cell(next_cell_t'{1'b0, j == cols - 1});
      row_at = '0;
      col_at = '0;
    end else if (c == cols - 1) begin
      row_at = r + side_t'(1);
      col_at = '0;
    end else begin
      row_at = r;
      col_at = c + side_t'(1);
    end
  endtask

  // Drop valid on the cell channel; call at a falling edge.
  task automatic idle_cells();
    if (cell_offer) begin
      cells_if.valid <= 1'b0;
      cell_offer = 1'b0;
    end
  endtask

  // Hold the sender until every owed result beat is out, then let it settle.
  task automatic drain_results();
    idle_cells();
    while (next_gen_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Offer one cell in the current burst; returns at the falling edge after its beat.
  task automatic send_cell(input logic alive, input logic typed, input next_cell_t typed_res);
    int base;
    if (burst_left == 0) begin
      // Burst over: usually open a gap, sometimes run straight into the next one
      if ($urandom_range(0, 3) != 0) begin
        idle_cells();
        repeat ($urandom_range(1, MAX_GAP)) @(negedge clk);
      end
      burst_left = $urandom_range(1, MAX_BURST);
    end
    cells_if.valid      <= 1'b1;
    cells_if.cell_alive <= alive;
    cell_offer = 1'b1;
    do @(posedge clk); while (!cells_if.ready);
    base = next_gen_q.size();
    step_generation(alive);
    if (typed && next_gen_q.size() > base) next_gen_q[base] = typed_res;
    cells_sent++;
    burst_left--;
    @(negedge clk);
  endtask

  // Write one register with the core idle; any write restarts the frame.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input side_t value);
    drain_results();
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    if (idx == REG_ROW_COUNT) rows_reg = value;
    else if (idx == REG_COLUMN_COUNT) cols_reg = value;
    row_at = '0;
    col_at = '0;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Size the board, then stream cells at the given live density (percent).
  // hold_at asks the receiver for its long hold-off; pause_at drains mid-frame.
  task automatic play_board(input side_t rows_val, input side_t cols_val, input int n_cells,
                            input int density, input int hold_at, input int pause_at);
    int i;
    write_reg(REG_ROW_COUNT, rows_val);
    write_reg(REG_COLUMN_COUNT, cols_val);
    for (i = 0; i < n_cells; i++) begin
      if (i == hold_at) holds_requested++;
      if (i == pause_at) drain_results();
      send_cell($urandom_range(0, 99) < density, 1'b0, DEAD_INNER);
    end
  endtask

  // Receiver: switch between randomly chosen stall patterns, and serve long
  // hold-off requests by counting them out here.
  initial begin : result_sink
    stall_mode_t mode;
    int          mode_left, hold_left, phase;
    results_if.ready = 1'b0;
    mode      = STALL_NONE;
    mode_left = 0;
    hold_left = 0;
    phase     = 0;
    forever begin
      @(negedge clk);
      if (holds_served != holds_requested) begin
        hold_left = HOLD_CYCLES;
        holds_served++;
      end
      if (mode_left == 0) begin
        mode      = stall_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(8, 80);
      end
      mode_left--;
      phase = (phase == 2) ? 0 : phase + 1;
      if (hold_left > 0) begin
        hold_left--;
        results_if.ready <= 1'b0;
      end else begin
        case (mode)
          STALL_NONE:        results_if.ready <= 1'b1;
          STALL_COIN:        results_if.ready <= 1'($urandom_range(0, 1));
          STALL_EVERY_THIRD: results_if.ready <= (phase != 0);
          default:           results_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Compare each result beat against the oldest owed cell
  always @(posedge clk) begin
    next_cell_t want;
    if (!rst && results_if.valid && results_if.ready) begin
      if (next_gen_q.size() == 0) begin
        $display("%0t: result beat with nothing owed: next_alive=%b frame_last=%b",
                 $time, results_if.next_alive, results_if.frame_last);
        errors++;
      end else begin
        want = next_gen_q.pop_front();
        if (results_if.next_alive !== want.alive) begin
          $display("%0t: next_alive expected %b actual %b",
                   $time, want.alive, results_if.next_alive);
          errors++;
        end
        if (results_if.frame_last !== want.frame_end) begin
          $display("%0t: frame_last expected %b actual %b",
                   $time, want.frame_end, results_if.frame_last);
          errors++;
        end
      end
    end
  end

  // Watchdog: end the run if no beat moves on any channel for too long
  always @(posedge clk) begin
    if (rst || (cells_if.valid && cells_if.ready) || (results_if.valid && results_if.ready)
        || (cfg_if.valid && cfg_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : stimulus
    int    pick, n_cells, frame, density;
    side_t rows_val, cols_val;

    // Drive every input to a known value before the first edge
    rst                 = 1'b1;
    cells_if.valid      = 1'b0;
    cells_if.cell_alive = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.index        = REG_ROW_COUNT;
    cfg_if.data         = '0;

    // Predictor starts from the reset state
    foreach (line_buf[k]) line_buf[k] = 1'b0;
    nbhd     = '0;
    row_at   = '0;
    col_at   = '0;
    rows_reg = side_t'(MAX_SIDE);
    cols_reg = side_t'(MAX_SIDE);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed walk
    foreach (DIRECTED_PLAN[k]) begin
      if (DIRECTED_PLAN[k].kind == STEP_WRITE)
        write_reg(DIRECTED_PLAN[k].index, DIRECTED_PLAN[k].data);
      else
        send_cell(DIRECTED_PLAN[k].alive, DIRECTED_PLAN[k].typed, DIRECTED_PLAN[k].typed_res);
    end

    // Widest board (column size above the ceiling) for one whole frame;
    // hold the receiver off part way in so the core backs up into its input
    play_board(side_t'(3), side_t'(63), 150, 50, 40, -1);
    // Tallest board (row size above the ceiling), cut short by the next write
    play_board(side_t'(63), side_t'(3), $urandom_range(12, 20), 45, -1, -1);

    // Small boards: mostly whole frames, sometimes two back to back to cross
    // the wrap; the rest are broken frames, a mid-frame drain, or sizes
    // below the floor
    while (cells_sent < DIRECTED_CELLS + RANDOM_CELLS) begin
      pick     = $urandom_range(0, 9);
      density  = $urandom_range(25, 75);
      rows_val = side_t'($urandom_range(3, 6));
      cols_val = side_t'($urandom_range(3, 6));
      if (pick == 0) begin
        rows_val = side_t'($urandom_range(0, 2));
        cols_val = side_t'($urandom_range(0, 2));
      end
      frame = int'(clamp_side(rows_val)) * int'(clamp_side(cols_val));
      if (pick == 1) begin
        // Broken frame, then a write past the register list to restart it
        play_board(rows_val, cols_val, $urandom_range(1, frame - 1), density, -1, -1);
        write_reg($urandom_range(0, 1) ? IDX_UNMAPPED_HI : IDX_UNMAPPED_LO,
                  side_t'($urandom_range(0, 63)));
      end else if (pick == 2) begin
        // Pause the sender mid-frame until every owed beat is out
        play_board(rows_val, cols_val, frame, density, -1, $urandom_range(1, frame - 1));
      end else begin
        n_cells = frame * $urandom_range(1, 2);
        play_board(rows_val, cols_val, n_cells, density, -1, -1);
      end
    end

    // Wait out every owed beat, then a tail for anything spurious
    idle_cells();
    while (next_gen_q.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: files.f
design/life_pkg.sv
design/life_if.sv
design/life_automaton_generation_core.v.sv
bench/tb_life_automaton_generation_core.sv
